>>> rtl/core/qrv_pkg.sv
`default_nettype none

package qrv_pkg;

  // Field widths
  localparam int unsigned QUAT_WIDTH = 16;
  localparam int unsigned VEC_WIDTH  = 16;

  // Input item: quaternion (Q2.14) and integer vector
  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] quat_w;
    logic signed [QUAT_WIDTH-1:0] quat_x;
    logic signed [QUAT_WIDTH-1:0] quat_y;
    logic signed [QUAT_WIDTH-1:0] quat_z;
    logic signed [VEC_WIDTH-1:0]  vec_x;
    logic signed [VEC_WIDTH-1:0]  vec_y;
    logic signed [VEC_WIDTH-1:0]  vec_z;
  } rot_in_t;

  // Result item: rotated vector and zero-norm flag
  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] rot_x;
    logic signed [VEC_WIDTH-1:0] rot_y;
    logic signed [VEC_WIDTH-1:0] rot_z;
    logic                        zero_quat;
  } rot_out_t;

endpackage

`default_nettype wire

>>> rtl/core/quaternion_rotate_vector.sv
`default_nettype none

// Quaternion vector rotation: rot = q * v * q^-1 with q^-1 = conj(q) / |q|^2.
//
// Input channel: item_i is taken at every rising edge with start high and busy
// low. busy is held low, so one item can be taken every cycle.
// Output channel: result_o is valid for exactly one cycle while
// result_valid_o is high; the receiver takes it at the end of that cycle and
// cannot stall, so results never back up.
// Throughput: one item per cycle. Five stages form the integer numerator and
// squared norm (products, sums, second products, numerator, magnitude), then a
// restoring divider with one stage per quotient bit (VEC_WIDTH + 1 stages)
// rounds to nearest, and one output register saturates and drives the ports.
// A zero quaternion gives a zero vector with zero_quat set.
// Reset clears every stage valid bit, so no result is shown after reset until
// new items have flowed through.
module quaternion_rotate_vector (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  qrv_pkg::rot_in_t   item_i,
  output logic               result_valid_o,
  output qrv_pkg::rot_out_t  result_o
);

  localparam int unsigned QW   = qrv_pkg::QUAT_WIDTH;
  localparam int unsigned VW   = qrv_pkg::VEC_WIDTH;
  localparam int unsigned SQW  = 2 * QW;
  localparam int unsigned SW   = 2 * QW + 2;
  localparam int unsigned DENW = 2 * QW + 1;
  localparam int unsigned PVW  = QW + VW;
  localparam int unsigned DW   = QW + VW + 2;
  localparam int unsigned CW   = QW + VW + 1;
  localparam int unsigned PSW  = SW + VW;
  localparam int unsigned PDW  = DW + QW;
  localparam int unsigned PCW  = QW + CW;
  localparam int unsigned NW   = 2 * QW + VW + 5;
  localparam int unsigned RW   = NW + 2;
  localparam int unsigned DVW  = DENW + 1;
  localparam int unsigned QUW  = VW + 1;
  localparam int unsigned NDIV = VW + 1;

  localparam logic [QUW-1:0] MAXP = QUW'((1 << (VW - 1)) - 1);
  localparam logic [QUW-1:0] MAXN = QUW'(1 << (VW - 1));

  // Accept every cycle
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Stage 1: products of the inputs
  logic                  vld1_q;
  logic signed [SQW-1:0] sq_q  [4];
  logic signed [PVW-1:0] dot_q [3];
  logic signed [PVW-1:0] crs_q [6];
  logic signed [QW-1:0]  qw1_q;
  logic signed [QW-1:0]  q1_q  [3];
  logic signed [VW-1:0]  v1_q  [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q[0]  <= item_i.quat_w * item_i.quat_w;
    sq_q[1]  <= item_i.quat_x * item_i.quat_x;
    sq_q[2]  <= item_i.quat_y * item_i.quat_y;
    sq_q[3]  <= item_i.quat_z * item_i.quat_z;
    dot_q[0] <= item_i.quat_x * item_i.vec_x;
    dot_q[1] <= item_i.quat_y * item_i.vec_y;
    dot_q[2] <= item_i.quat_z * item_i.vec_z;
    crs_q[0] <= item_i.quat_y * item_i.vec_z;
    crs_q[1] <= item_i.quat_z * item_i.vec_y;
    crs_q[2] <= item_i.quat_z * item_i.vec_x;
    crs_q[3] <= item_i.quat_x * item_i.vec_z;
    crs_q[4] <= item_i.quat_x * item_i.vec_y;
    crs_q[5] <= item_i.quat_y * item_i.vec_x;
    qw1_q    <= item_i.quat_w;
    q1_q[0]  <= item_i.quat_x;
    q1_q[1]  <= item_i.quat_y;
    q1_q[2]  <= item_i.quat_z;
    v1_q[0]  <= item_i.vec_x;
    v1_q[1]  <= item_i.vec_y;
    v1_q[2]  <= item_i.vec_z;
  end

  // Stage 2: norm, scalar term, dot and cross products
  logic                   vld2_q;
  logic        [DENW-1:0] den2_q;
  logic signed [SW-1:0]   s2_q;
  logic signed [DW-1:0]   d2_q;
  logic signed [CW-1:0]   c2_q [3];
  logic signed [QW-1:0]   qw2_q;
  logic signed [QW-1:0]   q2_q [3];
  logic signed [VW-1:0]   v2_q [3];
  logic signed [SW-1:0]   uu_s;
  logic signed [SW-1:0]   nrm_s;

  always_comb begin
    uu_s  = SW'(sq_q[1]) + SW'(sq_q[2]) + SW'(sq_q[3]);
    nrm_s = SW'(sq_q[0]) + uu_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    den2_q  <= nrm_s[DENW-1:0];
    s2_q    <= SW'(sq_q[0]) - uu_s;
    d2_q    <= DW'(dot_q[0]) + DW'(dot_q[1]) + DW'(dot_q[2]);
    c2_q[0] <= CW'(crs_q[0]) - CW'(crs_q[1]);
    c2_q[1] <= CW'(crs_q[2]) - CW'(crs_q[3]);
    c2_q[2] <= CW'(crs_q[4]) - CW'(crs_q[5]);
    qw2_q   <= qw1_q;
    q2_q    <= q1_q;
    v2_q    <= v1_q;
  end

  // Stage 3: second products, one set per lane
  logic                   vld3_q;
  logic                   zero3_q;
  logic        [DENW-1:0] den3_q;
  logic signed [PSW-1:0]  ps3_q [3];
  logic signed [PDW-1:0]  pd3_q [3];
  logic signed [PCW-1:0]  pc3_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    zero3_q <= (den2_q == '0);
    den3_q  <= den2_q;
    for (int l = 0; l < 3; l++) begin
      ps3_q[l] <= PSW'(s2_q) * PSW'(v2_q[l]);
      pd3_q[l] <= PDW'(d2_q) * PDW'(q2_q[l]);
      pc3_q[l] <= PCW'(qw2_q) * PCW'(c2_q[l]);
    end
  end

  // Stage 4: numerator per lane
  logic                   vld4_q;
  logic                   zero4_q;
  logic        [DENW-1:0] den4_q;
  logic signed [NW-1:0]   n4_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
    end else begin
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    zero4_q <= zero3_q;
    den4_q  <= den3_q;
    for (int l = 0; l < 3; l++) begin
      n4_q[l] <= NW'(ps3_q[l]) + (NW'(pd3_q[l]) <<< 1) + (NW'(pc3_q[l]) <<< 1);
    end
  end

  // Stage 5: magnitude and rounding offset, load the divider
  logic             vld_q  [NDIV+1];
  logic             zero_q [NDIV+1];
  logic [DVW-1:0]   dvs_q  [NDIV+1];
  logic [RW-1:0]    rem_q  [NDIV+1][3];
  logic [QUW-1:0]   quo_q  [NDIV+1][3];
  logic             neg_q  [NDIV+1][3];
  logic [NW-1:0]    mag_s  [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag_s[l] = n4_q[l][NW-1] ? NW'(-n4_q[l]) : NW'(n4_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NDIV; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= vld4_q;
      for (int k = 0; k < NDIV; k++) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  // Divider stages: one quotient bit each, top bit flags overflow
  logic [RW-1:0]  sub_s [NDIV][3];
  logic           ge_s  [NDIV][3];

  always_comb begin
    for (int k = 0; k < NDIV; k++) begin
      for (int l = 0; l < 3; l++) begin
        sub_s[k][l] = RW'(dvs_q[k]) << (VW - k);
        ge_s[k][l]  = (rem_q[k][l] >= sub_s[k][l]);
      end
    end
  end

  // Load the first stage and advance the divider
  always_ff @(posedge clk_i) begin
    zero_q[0] <= zero4_q;
    dvs_q[0]  <= {den4_q, 1'b0};
    for (int l = 0; l < 3; l++) begin
      rem_q[0][l] <= (RW'(mag_s[l]) << 1) + RW'(den4_q);
      quo_q[0][l] <= '0;
      neg_q[0][l] <= n4_q[l][NW-1];
    end
    for (int k = 0; k < NDIV; k++) begin
      zero_q[k+1] <= zero_q[k];
      dvs_q[k+1]  <= dvs_q[k];
      for (int l = 0; l < 3; l++) begin
        rem_q[k+1][l] <= ge_s[k][l] ? (rem_q[k][l] - sub_s[k][l]) : rem_q[k][l];
        quo_q[k+1][l] <= quo_q[k][l] | (QUW'(ge_s[k][l]) << (VW - k));
        neg_q[k+1][l] <= neg_q[k][l];
      end
    end
  end

  // Output: saturate, apply sign, zero on a zero quaternion
  logic [QUW-1:0] sat_s [3];
  logic [QUW-1:0] res_s [3];
  logic           vld_out_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (neg_q[NDIV][l]) begin
        sat_s[l] = (quo_q[NDIV][l] > MAXN) ? MAXN : quo_q[NDIV][l];
        res_s[l] = QUW'(-sat_s[l]);
      end else begin
        sat_s[l] = (quo_q[NDIV][l] > MAXP) ? MAXP : quo_q[NDIV][l];
        res_s[l] = sat_s[l];
      end
      if (zero_q[NDIV]) begin
        res_s[l] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[NDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    result_o.rot_x     <= res_s[0][VW-1:0];
    result_o.rot_y     <= res_s[1][VW-1:0];
    result_o.rot_z     <= res_s[2][VW-1:0];
    result_o.zero_quat <= zero_q[NDIV];
  end

  assign result_valid_o = vld_out_q;

`ifndef SYNTH
  // A result appears only for an item accepted earlier
  a_res_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, 23))
    else $error("result without matching item");

  // A zero quaternion always yields a zero vector
  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.zero_quat) |->
      (result_o.rot_x == '0 && result_o.rot_y == '0 && result_o.rot_z == '0))
    else $error("zero quaternion gave nonzero vector");
`endif

endmodule

`default_nettype wire

>>> tb/rotation_checker.sv
`timescale 1ns / 1ps

module rotation_checker (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  wire                busy_i,
  input  qrv_pkg::rot_in_t   item_i,
  input  wire                result_valid_i,
  input  qrv_pkg::rot_out_t  result_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  qrv_pkg::rot_out_t rotated_q[$];

  // Round num/den to nearest, ties away from zero, and clamp to the vector range.
  function automatic logic signed [qrv_pkg::VEC_WIDTH-1:0] divide_round_clamp(
    longint num, longint den);
    longint mag;
    longint quo;
    longint maxp;
    maxp = (64'sd1 <<< (qrv_pkg::VEC_WIDTH - 1)) - 1;
    mag = (num < 0) ? -num : num;
    quo = (2 * mag + den) / (2 * den);
    if (num < 0) begin
      if (quo > maxp + 1) quo = maxp + 1;
      quo = -quo;
      return quo[qrv_pkg::VEC_WIDTH-1:0];
    end
    if (quo > maxp) quo = maxp;
    return quo[qrv_pkg::VEC_WIDTH-1:0];
  endfunction

  // Compute the rotated vector for one item.
  function automatic qrv_pkg::rot_out_t rotate_item(qrv_pkg::rot_in_t it);
    qrv_pkg::rot_out_t r;
    longint qw, qx, qy, qz, vx, vy, vz, uu, den, s, d, cx, cy, cz;
    qw = it.quat_w; qx = it.quat_x; qy = it.quat_y; qz = it.quat_z;
    vx = it.vec_x; vy = it.vec_y; vz = it.vec_z;
    uu = qx * qx + qy * qy + qz * qz;
    den = qw * qw + uu;
    r = '0;
    if (den == 0) begin
      r.zero_quat = 1'b1;
      return r;
    end
    s = qw * qw - uu;
    d = qx * vx + qy * vy + qz * vz;
    cx = qy * vz - qz * vy;
    cy = qz * vx - qx * vz;
    cz = qx * vy - qy * vx;
    r.rot_x = divide_round_clamp(s * vx + 2 * d * qx + 2 * qw * cx, den);
    r.rot_y = divide_round_clamp(s * vy + 2 * d * qy + 2 * qw * cy, den);
    r.rot_z = divide_round_clamp(s * vz + 2 * d * qz + 2 * qw * cz, den);
    return r;
  endfunction

  assign pending_o = rotated_q.size();

  // Predict on each accepted item, compare on each result strobe.
  always @(posedge clk_i or negedge rst_ni) begin
    qrv_pkg::rot_out_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      rotated_q.delete();
    end else begin
      if (result_valid_i) begin
        if (rotated_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %h", result_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = rotated_q.pop_front();
          if (want.rot_x !== result_i.rot_x || want.rot_y !== result_i.rot_y ||
              want.rot_z !== result_i.rot_z || want.zero_quat !== result_i.zero_quat) begin
            if (fail_count_o < 10)
              $display("mismatch: expected x=%0d y=%0d z=%0d zq=%b, got x=%0d y=%0d z=%0d zq=%b",
                       want.rot_x, want.rot_y, want.rot_z, want.zero_quat,
                       result_i.rot_x, result_i.rot_y, result_i.rot_z, result_i.zero_quat);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i) rotated_q.push_back(rotate_item(item_i));
    end
  end
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  qrv_pkg::rot_in_t  item = '0;
  logic              result_valid;
  qrv_pkg::rot_out_t result;
  int                fail_count;
  int                pending;
  int                cycle_count = 0;
  int                idle_pct = 0;

  always #5 clk_i = ~clk_i;

  quaternion_rotate_vector u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item), .result_valid_o(result_valid), .result_o(result)
  );

  rotation_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy), .item_i(item),
    .result_valid_i(result_valid), .result_i(result),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Pick one quaternion or vector component, often at or near the extremes.
  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'h4000;
      4: return 16'hc000;
      5: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic qrv_pkg::rot_in_t random_item();
    qrv_pkg::rot_in_t it;
    it.quat_w = pick_field(); it.quat_x = pick_field();
    it.quat_y = pick_field(); it.quat_z = pick_field();
    it.vec_x = pick_field(); it.vec_y = pick_field(); it.vec_z = pick_field();
    if ($urandom_range(0, 9) == 0) {it.quat_w, it.quat_x, it.quat_y, it.quat_z} = '0;
    return it;
  endfunction

  // Present one item, idling first at the current rate, and hold until taken.
  task automatic send_item(qrv_pkg::rot_in_t it);
    while ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin
    qrv_pkg::rot_in_t it;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity, zero quaternion, half turns, extremes, saturation.
    send_item('{16'h4000, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h8000, 16'h1234});
    send_item('{16'h0, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h8000, 16'h0001});
    send_item('{16'h0, 16'h4000, 16'h0, 16'h0, 16'h0100, 16'h0200, 16'h0300});
    send_item('{16'h0, 16'h0, 16'h4000, 16'h0, 16'h8000, 16'h7fff, 16'h8000});
    send_item('{16'h0, 16'h0, 16'h0, 16'h4000, 16'h7fff, 16'h7fff, 16'h7fff});
    send_item('{16'h2d41, 16'h0, 16'h0, 16'h2d41, 16'h7fff, 16'h0, 16'h8000});
    send_item('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_item('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    send_item('{16'h0001, 16'h0001, 16'h0, 16'h0, 16'h7fff, 16'h8000, 16'h7fff});
    send_item('{16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001, 16'hffff, 16'h0});
    send_item('{16'h0, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0, 16'h0});
    send_item('{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0});

    // Random phases: no idling, heavy idling, light idling, no idling again.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 85 : (ph == 2) ? 10 : 0;
      for (int n = 0; n < 385; n++) begin
        it = random_item();
        send_item(it);
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
